/* rtl/pls_pkg.sv */
// Package for the positional list store: sizes, command and status codes,
// and the per-cell control word. No dependencies.
package pls_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CMD_W       = 2;
  localparam int POS_W       = 5;
  localparam int COUNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int STATUS_W    = 2;
  localparam int IN_BITS     = CMD_W + POS_W + VALUE_WIDTH;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = VALUE_WIDTH + COUNT_W + STATUS_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET    = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // What a cell loads in the current cycle; all low means hold.
  typedef struct packed {
    logic take_new;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage

/* rtl/pls_cell.sv */
// One storage cell of the list row: holds one element and loads the new
// value or a neighbor's element under control of the row decoder. Uses pls_pkg.
module pls_cell (
  input  logic                            clk,
  input  pls_pkg::cell_ctl_t              ctl,
  input  logic [pls_pkg::VALUE_WIDTH-1:0] new_value,
  input  logic [pls_pkg::VALUE_WIDTH-1:0] left_data,
  input  logic [pls_pkg::VALUE_WIDTH-1:0] right_data,
  output logic [pls_pkg::VALUE_WIDTH-1:0] data
);
  import pls_pkg::*;

  logic [VALUE_WIDTH-1:0] data_r;
  logic [VALUE_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.take_new) begin
      data_nxt = new_value;
    end else if (ctl.take_left) begin
      data_nxt = left_data;
    end else if (ctl.take_right) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

/* rtl/positional_list_store_unit.sv */
// Top level of the positional list store: command decode, the row of
// pls_cell elements, element count and the output register. Uses pls_pkg.
//
// Usage:
//   Input words carry a command (get, insert, remove), a position and, for
//   insert, a value. Each accepted word yields exactly one output word with
//   the element read (get/remove, else zero), the element count after the
//   command and a status (ok, bad position, list full).
//   The result is registered into the output register as the input word is
//   accepted. Throughput: one word per cycle while results are taken. All
//   cells load in the same cycle, so insert and remove shift the whole row at
//   once. The single output register parts the two sides: a new word is taken
//   when it is empty or while the held result is being taken in the same cycle.
//   When the receiver stalls, the result holds and in_tready drops until it
//   is taken; no word is lost or repeated.
//   Reset (rst_n low, synchronous) empties the list and drops the output
//   valid. Cell contents are not cleared; only elements below the count
//   are ever read.
module positional_list_store_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [1:0] command, [6:2] position, [38:7] new_value, [39] zero
  input  logic [pls_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] read_value, [36:32] element_count, [38:37] status, [39] zero
  output logic [pls_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pls_pkg::*;

  logic [CMD_W-1:0]       in_cmd;
  logic [POS_W-1:0]       in_pos;
  logic [VALUE_WIDTH-1:0] in_value;
  logic                   in_fire;
  logic                   ins_ok;
  logic                   rem_ok;

  logic [COUNT_W-1:0]     count_r;
  logic [COUNT_W-1:0]     count_nxt;
  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] out_read_r;
  logic [VALUE_WIDTH-1:0] out_read_nxt;
  logic [COUNT_W-1:0]     out_count_r;
  status_t                out_status_r;
  status_t                status_nxt;

  cell_ctl_t              ctl     [CAPACITY];
  logic [VALUE_WIDTH-1:0] cell_q  [CAPACITY];
  logic [VALUE_WIDTH-1:0] cell_rd;
  logic                   pos_in_list;

  assign in_cmd   = in_tdata[CMD_W-1:0];
  assign in_pos   = in_tdata[CMD_W+POS_W-1:CMD_W];
  assign in_value = in_tdata[IN_BITS-1:CMD_W+POS_W];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign pos_in_list = {1'b0, in_pos} < {1'b0, COUNT_W'(count_r)};
  assign ins_ok = in_fire && (in_cmd == CMD_INSERT)
                  && ({1'b0, in_pos} <= {1'b0, COUNT_W'(count_r)})
                  && (count_r < COUNT_W'(CAPACITY));
  assign rem_ok = in_fire && (in_cmd == CMD_REMOVE) && pos_in_list;

  // Row of cells: insert shifts up from the position, remove shifts down.
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_row
    logic [VALUE_WIDTH-1:0] left_d;
    logic [VALUE_WIDTH-1:0] right_d;

    assign ctl[gi].take_new   = ins_ok && (in_pos == POS_W'(gi));
    assign ctl[gi].take_left  = ins_ok && (in_pos < POS_W'(gi));
    assign ctl[gi].take_right = rem_ok && (in_pos <= POS_W'(gi));

    if (gi == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[gi+1];
    end

    pls_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[gi]),
      .new_value  (in_value),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_q[gi])
    );
  end

  assign cell_rd = cell_q[in_pos[IDX_W-1:0]];

  always_comb begin
    count_nxt    = count_r;
    out_read_nxt = '0;
    status_nxt   = ST_OK;
    case (in_cmd)
      CMD_GET: begin
        if (pos_in_list) begin
          out_read_nxt = cell_rd;
        end else begin
          status_nxt = ST_BADPOS;
        end
      end
      CMD_INSERT: begin
        if ({1'b0, in_pos} > {1'b0, COUNT_W'(count_r)}) begin
          status_nxt = ST_BADPOS;
        end else if (count_r >= COUNT_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + COUNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (pos_in_list) begin
          out_read_nxt = cell_rd;
          count_nxt    = count_r - COUNT_W'(1);
        end else begin
          status_nxt = ST_BADPOS;
        end
      end
      default: begin
        status_nxt = ST_BADPOS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_read_r   <= out_read_nxt;
      out_count_r  <= count_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_status_r, out_count_r, out_read_r});

  // Checks

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_FULL)) |-> (out_count_r == COUNT_W'(CAPACITY)))
    else $error("full status with list not full");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_read_r == '0))
    else $error("error result carries nonzero data");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ins_ok |=> (count_r == $past(count_r) + COUNT_W'(1)))
    else $error("insert did not grow the count");

endmodule

/* bench/list_reply_checker.sv */
`timescale 1ns / 1ps
// Checker for the positional list store: watches both stream channels, keeps
// its own copy of the list and compares every result word. Uses pls_pkg.
module list_reply_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // [1:0] command, [6:2] position, [38:7] new_value, [39] zero
  input  logic [pls_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] read_value, [36:32] element_count, [38:37] status, [39] zero
  input  logic [pls_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              outstanding,
  output int                              compared
);
  import pls_pkg::*;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [COUNT_W-1:0]     count;
    status_t                status;
  } list_reply_t;

  list_reply_t            list_replies[$];
  logic [VALUE_WIDTH-1:0] shadow_cells [CAPACITY];
  int                     shadow_len;
  int                     fail_tally;
  int                     compare_tally;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    compared    = 0;
    fail_tally  = 0;
    compare_tally = 0;
    shadow_len  = 0;
  end

  // Apply one command to the shadow list and return the word it must produce.
  function automatic list_reply_t list_op_reply(logic [CMD_W-1:0] cmd,
                                                logic [POS_W-1:0] pos,
                                                logic [VALUE_WIDTH-1:0] val);
    list_reply_t r;
    int          p;
    int          i;
    p        = int'(pos);
    r.value  = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_GET: begin
        if (p < shadow_len) r.value = shadow_cells[p];
        else r.status = ST_BADPOS;
      end
      CMD_INSERT: begin
        // position check wins over the full check
        if (p > shadow_len) begin
          r.status = ST_BADPOS;
        end else if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > p; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[p] = val;
          shadow_len++;
        end
      end
      CMD_REMOVE: begin
        if (p < shadow_len) begin
          r.value = shadow_cells[p];
          for (i = p; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_len--;
        end else begin
          r.status = ST_BADPOS;
        end
      end
      default: r.status = ST_BADPOS;
    endcase
    r.count = shadow_len[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("mismatch @%0t result %0d: %s expected 0x%0h got 0x%0h",
             $time, compare_tally, what, want, got);
    fail_tally++;
  endtask

  always @(posedge clk) begin
    list_reply_t            want;
    logic [VALUE_WIDTH-1:0] got_value;
    logic [COUNT_W-1:0]     got_count;
    logic [STATUS_W-1:0]    got_status;
    if (!rst_n) begin
      list_replies.delete();
      shadow_len = 0;
    end else begin
      // check the outgoing word first: it can never belong to a word taken at this edge
      if (out_tvalid && out_tready) begin
        got_value  = out_tdata[VALUE_WIDTH-1:0];
        got_count  = out_tdata[VALUE_WIDTH +: COUNT_W];
        got_status = out_tdata[VALUE_WIDTH+COUNT_W +: STATUS_W];
        if (list_replies.size() == 0) begin
          report_mismatch("word with nothing pending", 64'd0, 64'(out_tdata));
        end else begin
          want = list_replies.pop_front();
          if (got_value !== want.value)
            report_mismatch("read_value", 64'(want.value), 64'(got_value));
          if (got_count !== want.count)
            report_mismatch("element_count", 64'(want.count), 64'(got_count));
          if (got_status !== want.status)
            report_mismatch("status", 64'(want.status), 64'(got_status));
          compare_tally++;
        end
      end
      if (in_tvalid && in_tready)
        list_replies.push_back(list_op_reply(in_tdata[CMD_W-1:0],
                                             in_tdata[CMD_W +: POS_W],
                                             in_tdata[CMD_W+POS_W +: VALUE_WIDTH]));
    end
    outstanding <= list_replies.size();
    fail_count  <= fail_tally;
    compared    <= compare_tally;
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Top of the positional list store testbench: clock, reset, command stimulus
// and receiver stalls. Uses pls_pkg, list_reply_checker and the block itself.
module tb;
  import pls_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int RANDOM_WORDS = 850;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 4;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_mode_t;
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} cmd_mix_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int fail_count;
  int outstanding;
  int compared;

  int       cycle_count = 0;
  int       burst_left  = 0;
  int       list_len    = 0;
  int       full_hits   = 0;
  int       empty_hits  = 0;
  int       sent_per_cmd [4] = '{0, 0, 0, 0};
  rx_mode_t rx_mode     = RX_OPEN;
  int       rx_left     = 0;

  positional_list_store_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  list_reply_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .compared    (compared)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycle_count, outstanding);
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: switch between open, light and heavy stall patterns.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(50, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:  out_tready <= 1'b1;
      RX_LIGHT: out_tready <= ($urandom_range(0, 3) != 0);
      default:  out_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Insert a gap (sometimes none) between bursts of back-to-back words.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Drive one word and hold it until taken; track the list length for stimulus.
  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                          logic [VALUE_WIDTH-1:0] val);
    int p;
    p = int'(pos);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({val, pos, cmd});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_per_cmd[cmd]++;
    if (cmd == CMD_INSERT && p <= list_len && list_len < CAPACITY) begin
      list_len++;
      if (list_len == CAPACITY) full_hits++;
    end else if (cmd == CMD_REMOVE && p < list_len) begin
      list_len--;
      if (list_len == 0) empty_hits++;
    end
  endtask

  task automatic wait_all_replies();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return VALUE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(logic [CMD_W-1:0] cmd);
    if (cmd == CMD_UNKNOWN || $urandom_range(0, 99) >= 85)
      return POS_W'($urandom_range(0, 31));
    if (cmd == CMD_INSERT)
      return POS_W'($urandom_range(0, list_len));
    return (list_len == 0) ? '0 : POS_W'($urandom_range(0, list_len - 1));
  endfunction

  initial begin
    cmd_mix_t         mix;
    int               r;
    logic [CMD_W-1:0] cmd;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: everything but insert at the front is rejected
    send_cmd(CMD_GET,     5'd0, 32'h1111_1111);
    send_cmd(CMD_REMOVE,  5'd0, 32'h2222_2222);
    send_cmd(CMD_INSERT,  5'd1, 32'h3333_3333);
    send_cmd(CMD_UNKNOWN, 5'd0, 32'h4444_4444);
    // front, end and middle inserts
    send_cmd(CMD_INSERT,  5'd0, 32'hFFFF_FFFF);
    send_cmd(CMD_INSERT,  5'd1, 32'h0000_0000);
    send_cmd(CMD_INSERT,  5'd0, 32'h5A5A_5A5A);
    send_cmd(CMD_INSERT,  5'd2, 32'hA5A5_A5A5);
    send_cmd(CMD_GET,     5'd3, 32'h0);
    send_cmd(CMD_GET,     5'd4, 32'h0);
    send_cmd(CMD_GET,     5'd31, 32'hFFFF_FFFF);
    // fill to capacity
    while (list_len < CAPACITY)
      send_cmd(CMD_INSERT, POS_W'($urandom_range(0, list_len)), pick_value());
    send_cmd(CMD_INSERT,  5'd16, 32'hDEAD_0016);
    send_cmd(CMD_INSERT,  5'd17, 32'hDEAD_0017);
    send_cmd(CMD_GET,     5'd15, 32'h0);
    send_cmd(CMD_REMOVE,  5'd15, 32'h0);
    wait_all_replies();

    mix = MIX_EVEN;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 60 == 0) mix = cmd_mix_t'($urandom_range(0, 2));
      if (n == RANDOM_WORDS / 2) wait_all_replies();
      r = $urandom_range(0, 99);
      if (r < 3) cmd = CMD_UNKNOWN;
      else case (mix)
        MIX_FILL:  cmd = (r < 70) ? CMD_INSERT : (r < 85) ? CMD_REMOVE : CMD_GET;
        MIX_DRAIN: cmd = (r < 25) ? CMD_INSERT : (r < 75) ? CMD_REMOVE : CMD_GET;
        default:   cmd = (r < 40) ? CMD_INSERT : (r < 70) ? CMD_REMOVE : CMD_GET;
      endcase
      pace();
      send_cmd(cmd, pick_pos(cmd), pick_value());
    end

    wait_all_replies();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d get, %0d insert, %0d remove, %0d illegal words; %0d results compared",
             sent_per_cmd[CMD_GET], sent_per_cmd[CMD_INSERT], sent_per_cmd[CMD_REMOVE],
             sent_per_cmd[CMD_UNKNOWN], compared);
    $display("list reached capacity %0d times and drained empty %0d times",
             full_hits, empty_hits);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
